// ----- src/ble_pkg.sv -----
// shared types and constants for the bully leader election node
// no dependencies; imported by every module of the block
package ble_pkg;

   // largest group size the node supports; ids stay 3 bits
   localparam int MaxNodes = 8;
   localparam int TopLimit = (MaxNodes - 1 < 7) ? MaxNodes - 1 : 7;
   localparam logic [2:0] TopCap = 3'(TopLimit);

   localparam logic [2:0] ResetLeader = 3'd6;

   // configuration register indexes
   localparam logic [2:0] REG_OWN_ID         = 3'd0;
   localparam logic [2:0] REG_HIGHEST_ID     = 3'd1;
   localparam logic [2:0] REG_WAIT_TICKS     = 3'd2;
   localparam logic [2:0] REG_ELECTION_TICKS = 3'd3;
   localparam logic [2:0] REG_DEATH_TICKS    = 3'd4;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_LEADER = 3'd1,
      MODE_WAIT   = 3'd2,
      MODE_ELECT  = 3'd3,
      MODE_DEAD   = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      KIND_TICK  = 3'd0,
      KIND_MSG   = 3'd1,
      KIND_FAIL  = 3'd2,
      KIND_PING  = 3'd3,
      KIND_START = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      CODE_GENERIC  = 3'd0,
      CODE_ELECTION = 3'd1,
      CODE_OK       = 3'd2,
      CODE_COORD    = 3'd3,
      CODE_DEADW    = 3'd4
   } code_type;

   typedef enum logic [1:0] {
      DEST_NODE    = 2'd0,
      DEST_MONITOR = 2'd1,
      DEST_ALL     = 2'd2
   } dest_type;

   typedef struct packed {
      logic [2:0] own_id;
      logic [2:0] highest_id;
      logic [7:0] wait_ticks;
      logic [7:0] election_ticks;
      logic [7:0] death_ticks;
   } cfg_type;

   typedef struct packed {
      mode_type   mode;
      logic [2:0] leader;
      logic [7:0] countdown;
   } node_state_type;

   // burst of messages caused by one item: optional head, then an election sweep
   typedef struct packed {
      logic       head_vld;
      dest_type   head_dest;
      logic [2:0] head_id;
      code_type   head_code;
      logic       elec_vld;
      logic [2:0] elec_cur;
      logic [2:0] elec_top;
      logic [2:0] leader;
   } job_type;

endpackage

// ----- src/bully_leader_election_node_core.sv -----
// top level of the bully leader election node
// depends on ble_pkg, ble_cfg_regs, ble_step, ble_emit
//
// Usage: events enter on the req_ channel (tuser = event kind, tdata =
// message code and sender). Each accepted event updates mode, leader and
// countdown at once and produces a burst of 0 to 8 outgoing messages on
// the rsp_ channel, one per transfer, tlast on the final one of a burst.
// Events that send nothing produce no transfer at all.
// The first message of a burst passes the burst register, which takes the
// event at the transfer edge, and then the output register, which takes
// its first message from the burst register.
// Messages leave at one per cycle while the receiver takes them; an event
// holds the burst register until its last message moves to the output
// register, and the next event is taken in that cycle, so events sending
// nothing go back to back. Reset (synchronous, active high) sets mode idle,
// leader 6, countdown 0, the configuration registers to their defaults and
// drops rsp_tvalid. When the receiver stalls, the output register holds its
// message, the burst waits, and req_tready falls once the burst register is
// busy. Configuration is written through csr_ (index, data); the user must
// write it only while idle, and the block itself does not enforce this.
module bully_leader_election_node_core (
   input  logic        clock,
   input  logic        reset,
   // configuration write port
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [7:0]  csr_wdata,
   // event channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [2:0] msg_code, [5:3] sender_id
   input  logic [2:0]  req_tuser,   // [2:0] kind
   // outgoing message channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [2:0] dest_id, [5:3] out_code, [8:6] known_leader
   output logic [1:0]  rsp_tuser,   // [1:0] dest_kind
   output logic        rsp_tlast
);
   import ble_pkg::*;

   cfg_type        cfg;
   node_state_type state_ff;
   node_state_type state_in;
   node_state_type step_nxt;
   job_type        step_job;
   logic           emit_ready;
   logic           accept;

   ble_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ble_step u_step (
      .cfg       (cfg),
      .cur       (state_ff),
      .kind      (req_tuser),
      .msg_code  (req_tdata[2:0]),
      .sender_id (req_tdata[5:3]),
      .nxt       (step_nxt),
      .job       (step_job)
   );

   assign accept     = req_tvalid && emit_ready;
   assign req_tready = emit_ready;

   ble_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .new_job    (step_job),
      .ready      (emit_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // node state moves on every event transfer
   assign state_in = accept ? step_nxt : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode      <= MODE_IDLE;
         state_ff.leader    <= ResetLeader;
         state_ff.countdown <= 8'd0;
      end else begin
         state_ff <= state_in;
      end
   end

   // node state, in any mode, only changes on an event transfer
   a_mode_on_accept: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(state_ff))
      else $error("node state changed without an event");

   // a dead node stays dead on a tick that does not expire its countdown
   a_dead_exit: assert property (@(posedge clock) disable iff (reset)
      (accept && state_ff.mode == MODE_DEAD && req_tuser == KIND_TICK
       && state_ff.countdown > 8'd1) |=> (state_ff.mode == MODE_DEAD))
      else $error("dead node left dead early");

   // a burst with an election sweep always puts the node into electing mode
   a_elect_timer: assert property (@(posedge clock) disable iff (reset)
      (accept && step_job.elec_vld) |=> (state_ff.mode == MODE_ELECT))
      else $error("election messages without electing mode");

endmodule

// ----- src/ble_cfg_regs.sv -----
// configuration registers of the election node
// depends on ble_pkg
module ble_cfg_regs (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [2:0]       csr_addr,
   input  logic [7:0]       csr_wdata,
   output ble_pkg::cfg_type cfg
);
   import ble_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_OWN_ID:         cfg_in.own_id = csr_wdata[2:0];
            REG_HIGHEST_ID:     cfg_in.highest_id = csr_wdata[2:0];
            REG_WAIT_TICKS:     cfg_in.wait_ticks = csr_wdata;
            REG_ELECTION_TICKS: cfg_in.election_ticks = csr_wdata;
            REG_DEATH_TICKS:    cfg_in.death_ticks = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_id         <= 3'd6;
         cfg_ff.highest_id     <= 3'd6;
         cfg_ff.wait_ticks     <= 8'd5;
         cfg_ff.election_ticks <= 8'd10;
         cfg_ff.death_ticks    <= 8'd20;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- src/ble_step.sv -----
// next-state and message burst decision for one input item
// depends on ble_pkg; purely combinational
module ble_step (
   input  ble_pkg::cfg_type        cfg,
   input  ble_pkg::node_state_type cur,
   input  logic [2:0]              kind,
   input  logic [2:0]              msg_code,
   input  logic [2:0]              sender_id,
   output ble_pkg::node_state_type nxt,
   output ble_pkg::job_type        job
);
   import ble_pkg::*;

   logic       start_elec;
   logic       expired;
   logic       lower_election;
   logic [2:0] top_id;

   assign lower_election = (msg_code == CODE_ELECTION) && (sender_id < cfg.own_id);
   assign expired        = (cur.countdown <= 8'd1);
   assign top_id         = (cfg.highest_id > TopCap) ? TopCap : cfg.highest_id;

   always_comb begin
      nxt           = cur;
      start_elec    = 1'b0;
      job.head_vld  = 1'b0;
      job.head_dest = DEST_NODE;
      job.head_id   = 3'd0;
      job.head_code = CODE_GENERIC;

      case (kind)
         KIND_TICK: begin
            if (cur.mode inside {MODE_WAIT, MODE_ELECT, MODE_DEAD}) begin
               nxt.countdown = expired ? 8'd0 : cur.countdown - 8'd1;
               if (expired) begin
                  case (cur.mode)
                     MODE_WAIT: start_elec = 1'b1;
                     MODE_ELECT: begin
                        nxt.leader    = cfg.own_id;
                        nxt.mode      = MODE_LEADER;
                        job.head_vld  = 1'b1;
                        job.head_dest = DEST_ALL;
                        job.head_code = CODE_COORD;
                     end
                     default: begin
                        job.head_vld  = 1'b1;
                        job.head_dest = DEST_MONITOR;
                        job.head_code = CODE_DEADW;
                        start_elec    = 1'b1;
                     end
                  endcase
               end
            end
         end

         KIND_MSG: begin
            case (cur.mode)
               MODE_IDLE: begin
                  if (msg_code == CODE_COORD) begin
                     nxt.leader = sender_id;
                  end else if (lower_election) begin
                     job.head_vld  = 1'b1;
                     job.head_id   = sender_id;
                     job.head_code = CODE_OK;
                     start_elec    = 1'b1;
                  end
               end
               MODE_LEADER: begin
                  if (lower_election) begin
                     job.head_vld  = 1'b1;
                     job.head_id   = sender_id;
                     job.head_code = CODE_OK;
                  end else if (msg_code == CODE_COORD && sender_id != cfg.own_id) begin
                     nxt.leader = sender_id;
                     nxt.mode   = MODE_IDLE;
                  end else if (msg_code == CODE_GENERIC) begin
                     job.head_vld  = 1'b1;
                     job.head_id   = sender_id;
                     job.head_code = CODE_GENERIC;
                  end
               end
               MODE_WAIT: begin
                  if (msg_code == CODE_COORD) begin
                     nxt.leader = sender_id;
                     nxt.mode   = MODE_IDLE;
                  end else if (lower_election) begin
                     job.head_vld  = 1'b1;
                     job.head_id   = sender_id;
                     job.head_code = CODE_OK;
                     start_elec    = 1'b1;
                  end else if (msg_code == CODE_GENERIC) begin
                     nxt.mode = MODE_IDLE;
                  end
               end
               MODE_ELECT: begin
                  if (msg_code == CODE_COORD) begin
                     nxt.leader = sender_id;
                  end else if (lower_election) begin
                     job.head_vld  = 1'b1;
                     job.head_id   = sender_id;
                     job.head_code = CODE_OK;
                  end else if (msg_code == CODE_OK) begin
                     nxt.mode = MODE_IDLE;
                  end
               end
               default: nxt = cur;
            endcase
         end

         KIND_FAIL: begin
            if (cur.mode != MODE_DEAD) begin
               job.head_vld  = 1'b1;
               job.head_dest = DEST_MONITOR;
               job.head_code = CODE_DEADW;
               nxt.mode      = MODE_DEAD;
               nxt.countdown = cfg.death_ticks;
            end
         end

         KIND_PING: begin
            if (cur.mode == MODE_IDLE) begin
               job.head_vld  = 1'b1;
               job.head_id   = cur.leader;
               job.head_code = CODE_GENERIC;
               nxt.mode      = MODE_WAIT;
               nxt.countdown = cfg.wait_ticks;
            end
         end

         KIND_START: begin
            nxt.leader    = cfg.highest_id;
            nxt.countdown = 8'd0;
            nxt.mode      = (cfg.own_id == cfg.highest_id) ? MODE_LEADER : MODE_IDLE;
         end

         default: nxt = cur;
      endcase

      // entering electing: sweep ELECTION over the higher ids
      job.elec_vld = 1'b0;
      job.elec_cur = cfg.own_id + 3'd1;
      job.elec_top = top_id;
      if (start_elec) begin
         nxt.mode      = MODE_ELECT;
         nxt.countdown = cfg.election_ticks;
         job.elec_vld  = (cfg.own_id < top_id);
      end
      job.leader = nxt.leader;
   end

endmodule

// ----- src/ble_emit.sv -----
// burst register and output register: sends one message per transfer
// depends on ble_pkg
module ble_emit (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  ble_pkg::job_type new_job,
   output logic             ready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [15:0]      rsp_tdata,
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast
);
   import ble_pkg::*;

   job_type    job_ff;
   job_type    job_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [1:0] dest_ff;
   logic [1:0] dest_in;
   logic [2:0] id_ff;
   logic [2:0] id_in;
   logic [2:0] code_ff;
   logic [2:0] code_in;
   logic [2:0] leader_ff;
   logic       last_ff;
   logic       last_in;
   logic       job_vld;
   logic       pop;
   logic       job_done;

   assign job_vld  = job_ff.head_vld || job_ff.elec_vld;
   assign pop      = job_vld && (!rsp_valid_ff || rsp_tready);
   assign last_in  = job_ff.head_vld ? !job_ff.elec_vld
                                     : (job_ff.elec_cur == job_ff.elec_top);
   assign job_done = pop && last_in;
   assign ready    = !job_vld || job_done;

   // pick the message at the head of the burst
   always_comb begin
      if (job_ff.head_vld) begin
         dest_in = job_ff.head_dest;
         id_in   = job_ff.head_id;
         code_in = job_ff.head_code;
      end else begin
         dest_in = DEST_NODE;
         id_in   = job_ff.elec_cur;
         code_in = CODE_ELECTION;
      end
   end

   // advance the burst or take a new one
   always_comb begin
      job_in = job_ff;
      if (load) begin
         job_in = new_job;
      end else if (pop) begin
         if (job_ff.head_vld) begin
            job_in.head_vld = 1'b0;
         end else begin
            job_in.elec_cur = job_ff.elec_cur + 3'd1;
            job_in.elec_vld = !last_in;
         end
      end
   end

   always_comb begin
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_ff.head_vld <= 1'b0;
         job_ff.elec_vld <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         job_ff       <= job_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (pop) begin
         dest_ff   <= dest_in;
         id_ff     <= id_in;
         code_ff   <= code_in;
         last_ff   <= last_in;
         leader_ff <= job_ff.leader;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, leader_ff, code_ff, id_ff};
   assign rsp_tuser  = dest_ff;
   assign rsp_tlast  = last_ff;

   // election sweep never runs past its top id
   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      job_ff.elec_vld |-> (job_ff.elec_cur <= job_ff.elec_top))
      else $error("election sweep beyond top id");

   // a burst with messages left stays pending
   a_burst_kept: assert property (@(posedge clock) disable iff (reset)
      (pop && !last_in) |=> job_vld)
      else $error("burst dropped before its last message");

   // a pending burst always fills an empty output register
   a_fill_output: assert property (@(posedge clock) disable iff (reset)
      (job_vld && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("output register left empty with a burst pending");

   // a new item is only taken when the burst register frees up
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> (!job_vld || job_done))
      else $error("burst overwritten while messages remain");

endmodule

// ----- bench/bully_leader_election_node_core_test.sv -----
// self-checking bench for the bully leader election node core: predicts the
// outgoing message bursts of every event and checks them as they leave the block
// depends on ble_pkg and bully_leader_election_node_core
`timescale 1ns / 1ps

module bully_leader_election_node_core_test;
   import ble_pkg::*;

   localparam int QuietLimit = 1000;
   localparam int HoldCycles = 80;

   // one outgoing message as the node should send it
   typedef struct {
      dest_type   dest;
      logic [2:0] node;
      code_type   code;
      logic       is_last;
      logic [2:0] leader;
   } outgoing_msg_type;

   // node predictor plus the store of messages still owed by the block
   class election_scoreboard;
      cfg_type          cfg;
      mode_type         mode;
      logic [2:0]       leader;
      logic [7:0]       countdown;
      outgoing_msg_type pending[$];
      outgoing_msg_type burst[$];
      int               accepted;
      int               checked;
      int               errors;

      function void reset_state();
         cfg.own_id         = 3'd6;
         cfg.highest_id     = 3'd6;
         cfg.wait_ticks     = 8'd5;
         cfg.election_ticks = 8'd10;
         cfg.death_ticks    = 8'd20;
         mode      = MODE_IDLE;
         leader    = ResetLeader;
         countdown = 8'd0;
         pending.delete();
      endfunction

      function void write_reg(logic [2:0] idx, logic [7:0] value);
         case (idx)
            REG_OWN_ID:         cfg.own_id = value[2:0];
            REG_HIGHEST_ID:     cfg.highest_id = value[2:0];
            REG_WAIT_TICKS:     cfg.wait_ticks = value;
            REG_ELECTION_TICKS: cfg.election_ticks = value;
            REG_DEATH_TICKS:    cfg.death_ticks = value;
            default: ;
         endcase
      endfunction

      function void send(dest_type dest, logic [2:0] node, code_type code);
         outgoing_msg_type m;
         m.dest    = dest;
         m.node    = node;
         m.code    = code;
         m.is_last = 1'b0;
         m.leader  = 3'd0;
         if (burst.size() < 8) burst.push_back(m);
      endfunction

      // election sweep to every higher id, then count down for an ok
      function void open_election();
         int top;
         int j;
         top = cfg.highest_id;
         if (top > TopLimit) top = TopLimit;
         for (j = int'(cfg.own_id) + 1; j <= top; j++)
            send(DEST_NODE, 3'(j), CODE_ELECTION);
         mode      = MODE_ELECT;
         countdown = cfg.election_ticks;
      endfunction

      function void on_tick();
         logic expired;
         if (mode != MODE_WAIT && mode != MODE_ELECT && mode != MODE_DEAD) return;
         expired   = countdown <= 8'd1;
         countdown = expired ? 8'd0 : countdown - 8'd1;
         if (!expired) return;
         case (mode)
            MODE_WAIT: open_election();
            MODE_ELECT: begin
               leader = cfg.own_id;
               send(DEST_ALL, 3'd0, CODE_COORD);
               mode = MODE_LEADER;
            end
            default: begin
               send(DEST_MONITOR, 3'd0, CODE_DEADW);
               open_election();
            end
         endcase
      endfunction

      function void on_message(logic [2:0] code, logic [2:0] sender);
         logic lower_election;
         lower_election = (code == CODE_ELECTION) && (sender < cfg.own_id);
         case (mode)
            MODE_IDLE: begin
               if (code == CODE_COORD) begin
                  leader = sender;
               end else if (lower_election) begin
                  send(DEST_NODE, sender, CODE_OK);
                  open_election();
               end
            end
            MODE_LEADER: begin
               if (lower_election) begin
                  send(DEST_NODE, sender, CODE_OK);
               end else if (code == CODE_COORD && sender != cfg.own_id) begin
                  leader = sender;
                  mode   = MODE_IDLE;
               end else if (code == CODE_GENERIC) begin
                  send(DEST_NODE, sender, CODE_GENERIC);
               end
            end
            MODE_WAIT: begin
               if (code == CODE_COORD) begin
                  leader = sender;
                  mode   = MODE_IDLE;
               end else if (lower_election) begin
                  send(DEST_NODE, sender, CODE_OK);
                  open_election();
               end else if (code == CODE_GENERIC) begin
                  mode = MODE_IDLE;
               end
            end
            MODE_ELECT: begin
               if (code == CODE_COORD) begin
                  leader = sender;
               end else if (lower_election) begin
                  send(DEST_NODE, sender, CODE_OK);
               end else if (code == CODE_OK) begin
                  mode = MODE_IDLE;
               end
            end
            default: ;
         endcase
      endfunction

      // accepted event: advance the node and queue the burst it causes
      function void note_request(logic [2:0] kind, logic [2:0] code, logic [2:0] sender);
         burst.delete();
         accepted++;
         case (kind)
            KIND_TICK: on_tick();
            KIND_MSG:  on_message(code, sender);
            KIND_FAIL: begin
               if (mode != MODE_DEAD) begin
                  send(DEST_MONITOR, 3'd0, CODE_DEADW);
                  mode      = MODE_DEAD;
                  countdown = cfg.death_ticks;
               end
            end
            KIND_PING: begin
               if (mode == MODE_IDLE) begin
                  send(DEST_NODE, leader, CODE_GENERIC);
                  mode      = MODE_WAIT;
                  countdown = cfg.wait_ticks;
               end
            end
            KIND_START: begin
               leader    = cfg.highest_id;
               countdown = 8'd0;
               mode      = (cfg.own_id == cfg.highest_id) ? MODE_LEADER : MODE_IDLE;
            end
            default: ;
         endcase
         foreach (burst[k]) begin
            burst[k].is_last = (k == burst.size() - 1);
            burst[k].leader  = leader;
            pending.push_back(burst[k]);
         end
      endfunction

      function void check_response(logic [1:0] dest, logic [2:0] node, logic [2:0] code,
                                   logic is_last, logic [2:0] leader_seen);
         outgoing_msg_type want;
         if (pending.size() == 0) begin
            $error("message with nothing expected: dest_kind %0d dest_id %0d out_code %0d",
                   dest, node, code);
            errors++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (dest !== want.dest) begin
            $error("dest_kind expected %0d got %0d", want.dest, dest);
            errors++;
         end
         if (node !== want.node) begin
            $error("dest_id expected %0d got %0d", want.node, node);
            errors++;
         end
         if (code !== want.code) begin
            $error("out_code expected %0d got %0d", want.code, code);
            errors++;
         end
         if (is_last !== want.is_last) begin
            $error("last expected %0d got %0d", want.is_last, is_last);
            errors++;
         end
         if (leader_seen !== want.leader) begin
            $error("known_leader expected %0d got %0d", want.leader, leader_seen);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = 3'd0;
   logic [7:0]  csr_wdata = 8'd0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [2:0] msg_code, [5:3] sender_id
   logic [2:0]  req_tuser = 3'd0;   // [2:0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // [2:0] dest_id, [5:3] out_code, [8:6] known_leader
   logic [1:0]  rsp_tuser;          // [1:0] dest_kind
   logic        rsp_tlast;

   logic        steady = 1'b0;
   logic        hold_request = 1'b0;
   logic        hold_done = 1'b0;
   int          hold_left = 0;
   int          quiet_cycles = 0;
   int          settings_count = 0;

   election_scoreboard sb;

   bully_leader_election_node_core DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver: random stalls, one long hold-off on request, none while steady
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_request && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_left  <= HoldCycles;
         hold_done  <= 1'b1;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= 12);
      end
   end

   // every message transfer is checked against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tuser, rsp_tdata[2:0], rsp_tdata[5:3], rsp_tlast,
                           rsp_tdata[8:6]);
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QuietLimit) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   task automatic write_settings(input logic [2:0] own, input logic [2:0] highest,
                                 input logic [7:0] wt, input logic [7:0] et,
                                 input logic [7:0] dt);
      write_reg(REG_OWN_ID, {5'd0, own});
      write_reg(REG_HIGHEST_ID, {5'd0, highest});
      write_reg(REG_WAIT_TICKS, wt);
      write_reg(REG_ELECTION_TICKS, et);
      write_reg(REG_DEATH_TICKS, dt);
      csr_we <= 1'b0;
      settings_count++;
   endtask

   // one event transfer, with a random gap ahead of it
   task automatic send_item(input logic [2:0] kind, input logic [2:0] code,
                            input logic [2:0] sender);
      while (!steady && $urandom_range(99) < 12) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {2'b00, sender, code};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(kind, code, sender);
   endtask

   // mostly ticks while a countdown runs, otherwise mostly messages
   task automatic send_random();
      int         pick;
      logic       counting;
      logic [2:0] kind;
      logic [2:0] code;
      logic [2:0] sender;
      pick     = $urandom_range(99);
      counting = sb.mode == MODE_WAIT || sb.mode == MODE_ELECT || sb.mode == MODE_DEAD;
      sender   = 3'($urandom_range(7));
      code     = ($urandom_range(99) < 8) ? 3'($urandom_range(7)) : 3'($urandom_range(3));
      if (pick < (counting ? 55 : 25)) kind = KIND_TICK;
      else if (pick < 75) kind = KIND_MSG;
      else if (pick < 83) kind = KIND_PING;
      else if (pick < 89) kind = KIND_FAIL;
      else if (pick < 95) kind = KIND_START;
      else kind = 3'($urandom_range(7));
      send_item(kind, code, sender);
   endtask

   // sender pause until every owed message is out and the block is quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      int phase;
      int n;
      sb = new();
      sb.reset_state();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed walk through every mode with short timeouts
      write_settings(3'd2, 3'd7, 8'd2, 8'd2, 8'd2);
      send_item(KIND_START, CODE_GENERIC, 3'd0);
      send_item(KIND_MSG, CODE_COORD, 3'd5);
      send_item(KIND_PING, CODE_GENERIC, 3'd0);
      send_item(KIND_TICK, CODE_GENERIC, 3'd0);
      send_item(KIND_TICK, CODE_GENERIC, 3'd0);
      send_item(KIND_MSG, CODE_ELECTION, 3'd1);
      send_item(KIND_MSG, CODE_COORD, 3'd7);
      send_item(KIND_TICK, CODE_GENERIC, 3'd0);
      send_item(KIND_TICK, CODE_GENERIC, 3'd0);
      send_item(KIND_MSG, CODE_GENERIC, 3'd4);
      send_item(KIND_MSG, CODE_ELECTION, 3'd0);
      send_item(KIND_MSG, CODE_ELECTION, 3'd5);
      send_item(KIND_MSG, CODE_DEADW, 3'd3);
      send_item(KIND_MSG, 3'd7, 3'd7);          // code with no meaning
      send_item(KIND_MSG, CODE_COORD, 3'd2);
      send_item(KIND_MSG, CODE_COORD, 3'd6);
      send_item(KIND_MSG, CODE_ELECTION, 3'd1);
      send_item(KIND_MSG, CODE_OK, 3'd6);
      send_item(KIND_FAIL, CODE_GENERIC, 3'd0);
      send_item(KIND_FAIL, CODE_GENERIC, 3'd0);
      send_item(KIND_MSG, CODE_GENERIC, 3'd6);
      send_item(KIND_PING, CODE_GENERIC, 3'd0);
      send_item(KIND_TICK, CODE_GENERIC, 3'd0);
      send_item(KIND_TICK, CODE_GENERIC, 3'd0);
      send_item(3'd7, CODE_GENERIC, 3'd0);      // kind with no meaning
      settle();

      // random phases, each under its own register setting
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: write_settings(3'd0, 3'd7, 8'd1, 8'd1, 8'd1);
            1: write_settings(3'd7, 3'd7, 8'd255, 8'd255, 8'd255);
            2: write_settings(3'd3, 3'd5, 8'd0, 8'd0, 8'd0);
            3: write_settings(3'd5, 3'd2, 8'd3, 8'd4, 8'd3);
            default: write_settings(3'($urandom_range(7)), 3'($urandom_range(7, 1)),
                                    8'($urandom_range(6, 1)), 8'($urandom_range(6, 1)),
                                    8'($urandom_range(8, 1)));
         endcase
         // long receiver hold-off under the widest election sweep
         if (phase == 0) hold_request <= 1'b1;
         if (phase == 1) steady <= 1'b1;
         if (phase == 2) steady <= 1'b0;
         send_item(KIND_START, CODE_GENERIC, 3'd0);
         if (phase == 0) begin
            send_item(KIND_PING, CODE_GENERIC, 3'd0);
            send_item(KIND_TICK, CODE_GENERIC, 3'd0);
            send_item(KIND_FAIL, CODE_GENERIC, 3'd0);
            send_item(KIND_TICK, CODE_GENERIC, 3'd0);
         end
         for (n = 0; n < 16; n++) send_random();
         settle();
      end

      $display("covered %0d events under %0d register settings, %0d messages checked",
               sb.accepted, settings_count, sb.checked);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
